// ===== rtl/pwm_motor_mode_controller_unit_macros.svh =====
// ----------------------------------------------------------------------------
// PWM motor mode controller - assertion macros
// Shared concurrent assertion shorthands for the controller RTL.
// ----------------------------------------------------------------------------
`ifndef PWM_MOTOR_MODE_CONTROLLER_UNIT_MACROS_SVH
`define PWM_MOTOR_MODE_CONTROLLER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PMMC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pmmc assertion failed (same cycle)");

// Next-cycle implication, disabled while reset is asserted.
`define PMMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pmmc assertion failed (next cycle)");

`endif

// ===== rtl/pmmc_pkg.sv =====
// ----------------------------------------------------------------------------
// pmmc_pkg
// Types and constants shared by the PWM motor mode controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pmmc_pkg;

    localparam int DEF_TICK_WIDTH    = 16;
    localparam int DEF_ENCODER_WIDTH = 32;

    // Fixed widths of the request and result fields
    localparam int ENC_IN_W = 32;
    localparam int DELTA_W  = 32;

    // Configuration port
    localparam int DATA_W      = 32;
    localparam int PADDR_W     = 3;
    localparam int REG_SEL_BIT = 2;

    localparam logic REG_PERIOD = 1'b0;
    localparam logic REG_ON     = 1'b1;

    typedef enum logic [3:0] {
        MODE_START = 4'd0,
        MODE_LOW   = 4'd1,
        MODE_HIGH  = 4'd2,
        MODE_SPEED = 4'd3,
        MODE_FULL  = 4'd4,
        MODE_PULSE = 4'd5,
        MODE_ERROR = 4'd6,
        MODE_DONE  = 4'd7,
        MODE_STOP  = 4'd8
    } t_mode;

    typedef struct packed {
        logic                      drive_off;
        logic                      speed_valid;
        logic signed [DELTA_W-1:0] enc_delta;
        logic                      runaway;
        logic                      halted;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/pmmc_if.sv =====
// ----------------------------------------------------------------------------
// pmmc_in_if / pmmc_out_if
// Valid/ready channels for tick requests and per-tick results.
// ----------------------------------------------------------------------------
`default_nettype none

interface pmmc_in_if;
    logic        valid;
    logic        ready;
    logic        stop_switch_n;
    logic        speed_switch_n;
    logic [31:0] encoder_count;

    modport source (output valid, stop_switch_n, speed_switch_n, encoder_count,
                    input ready);
    modport sink   (input valid, stop_switch_n, speed_switch_n, encoder_count,
                    output ready);
endinterface

interface pmmc_out_if;
    logic               valid;
    logic               ready;
    logic               drive_off;
    logic               speed_valid;
    logic signed [31:0] enc_delta;
    logic               runaway;
    logic               halted;

    modport source (output valid, drive_off, speed_valid, enc_delta, runaway, halted,
                    input ready);
    modport sink   (input valid, drive_off, speed_valid, enc_delta, runaway, halted,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/pwm_motor_mode_controller_unit.sv =====
// ----------------------------------------------------------------------------
// pwm_motor_mode_controller_unit
// PWM motor mode controller with tick request/result channels and APB setup.
// ----------------------------------------------------------------------------
// Each request is one PWM tick and yields exactly one result. A request is
// taken into an input register, the mode machine evaluates it from there
// and the result lands in an output register once that register is free or
// draining; a new request is accepted every cycle while the result side
// keeps taking results, so throughput is set only by the result channel's
// ready. The period and on-time registers (byte addresses 0 and 4) are meant
// to be written while no request is in flight.
`default_nettype none

`include "pwm_motor_mode_controller_unit_macros.svh"

module pwm_motor_mode_controller_unit #(
    parameter int TICK_WIDTH    = pmmc_pkg::DEF_TICK_WIDTH,
    parameter int ENCODER_WIDTH = pmmc_pkg::DEF_ENCODER_WIDTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    pmmc_in_if.sink                            i_in,
    pmmc_out_if.source                         o_out,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pmmc_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [pmmc_pkg::DATA_W-1:0]   pwdata,
    output logic      [pmmc_pkg::DATA_W-1:0]   prdata,
    output logic                               pready
);
    import pmmc_pkg::*;

    logic [TICK_WIDTH-1:0]    r_period;
    logic [TICK_WIDTH-1:0]    r_on;
    logic                     r_in_valid;
    logic                     r_stop_n;
    logic                     r_speed_n;
    logic [ENCODER_WIDTH-1:0] r_enc;
    logic                     r_out_valid;
    t_result                  r_res;
    t_result                  s_result;
    logic                     s_advance;
    logic                     s_cfg_wr;

    // Configuration registers
    assign pready   = 1'b1;
    assign s_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= TICK_WIDTH'(10);
            r_on     <= TICK_WIDTH'(5);
        end else if (s_cfg_wr) begin
            case (paddr[REG_SEL_BIT])
                REG_PERIOD: r_period <= pwdata[TICK_WIDTH-1:0];
                REG_ON:     r_on     <= pwdata[TICK_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[REG_SEL_BIT])
            REG_PERIOD: prdata = DATA_W'(r_period);
            REG_ON:     prdata = DATA_W'(r_on);
            default:    prdata = '0;
        endcase
    end

    // Input stage: advance whenever the result register is free or draining
    assign s_advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || s_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_stop_n  <= i_in.stop_switch_n;
            r_speed_n <= i_in.speed_switch_n;
            r_enc     <= i_in.encoder_count[ENCODER_WIDTH-1:0];
        end
    end

    pmmc_mode_fsm #(
        .TICK_WIDTH    (TICK_WIDTH),
        .ENCODER_WIDTH (ENCODER_WIDTH)
    ) u_mode_fsm (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (s_advance),
        .i_stop_switch_n  (r_stop_n),
        .i_speed_switch_n (r_speed_n),
        .i_encoder_count  (r_enc),
        .i_period_ticks   (r_period),
        .i_on_ticks       (r_on),
        .o_result         (s_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_advance) begin
            r_res <= s_result;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.drive_off   = r_res.drive_off;
    assign o_out.speed_valid = r_res.speed_valid;
    assign o_out.enc_delta   = r_res.enc_delta;
    assign o_out.runaway     = r_res.runaway;
    assign o_out.halted      = r_res.halted;

    // Once halted, every later result stays halted
    `PMMC_ASSERT_NEXT(a_halt_sticky, i_clk, i_rst_n, r_out_valid && r_res.halted && s_advance, r_res.halted)
    // A nonzero delta only comes with a speed sample
    `PMMC_ASSERT_NOW(a_delta_needs_sample, i_clk, i_rst_n, r_out_valid && (r_res.enc_delta != '0), r_res.speed_valid)
    // An empty result register never blocks the request side
    `PMMC_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !r_out_valid, i_in.ready)

endmodule

`default_nettype wire

// ===== rtl/pmmc_mode_fsm.sv =====
// ----------------------------------------------------------------------------
// pmmc_mode_fsm
// Mode machine of the controller: runs one tick per step strobe and
// presents the tick's result combinationally from the current state.
// ----------------------------------------------------------------------------
`default_nettype none

module pmmc_mode_fsm #(
    parameter int TICK_WIDTH    = 16,
    parameter int ENCODER_WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_step,
    input  wire logic                     i_stop_switch_n,
    input  wire logic                     i_speed_switch_n,
    input  wire logic [ENCODER_WIDTH-1:0] i_encoder_count,
    input  wire logic [TICK_WIDTH-1:0]    i_period_ticks,
    input  wire logic [TICK_WIDTH-1:0]    i_on_ticks,
    output pmmc_pkg::t_result             o_result
);
    import pmmc_pkg::*;

    localparam int CW = TICK_WIDTH + 1;

    t_mode                    r_mode, n_mode, s_mode_run;
    logic [CW-1:0]            r_tick, n_tick;
    logic                     r_drive, n_drive;
    logic                     r_full_seen, n_full_seen;
    logic                     r_pulse_seen, n_pulse_seen;
    logic [CW-1:0]            r_full_phase, n_full_phase;
    logic [CW-1:0]            r_pulse_phase, n_pulse_phase;
    logic [ENCODER_WIDTH-1:0] r_prev, n_prev;
    logic                     r_baseline, n_baseline;
    logic                     r_done, n_done;

    logic [CW-1:0]            s_per_ext, s_on_ext, s_limit;
    logic [CW-1:0]            s_full_inc, s_pulse_inc, s_pulse_wrap;
    logic [ENCODER_WIDTH-1:0] s_enc_diff;
    logic                     s_valid, s_runaway;
    logic signed [DELTA_W-1:0] s_delta;

    assign s_per_ext    = {1'b0, i_period_ticks};
    assign s_on_ext     = {1'b0, i_on_ticks};
    assign s_limit      = s_per_ext + CW'(2);
    assign s_full_inc   = r_full_phase + CW'(1);
    assign s_pulse_inc  = r_pulse_phase + CW'(1);
    assign s_pulse_wrap = (s_pulse_inc > s_per_ext) ? '0 : s_pulse_inc;
    assign s_enc_diff   = i_encoder_count - r_prev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_START;
            r_tick        <= '0;
            r_drive       <= 1'b0;
            r_full_seen   <= 1'b0;
            r_pulse_seen  <= 1'b0;
            r_full_phase  <= '0;
            r_pulse_phase <= '0;
            r_prev        <= '0;
            r_baseline    <= 1'b0;
            r_done        <= 1'b0;
        end else if (i_step) begin
            r_mode        <= n_mode;
            r_tick        <= n_tick;
            r_drive       <= n_drive;
            r_full_seen   <= n_full_seen;
            r_pulse_seen  <= n_pulse_seen;
            r_full_phase  <= n_full_phase;
            r_pulse_phase <= n_pulse_phase;
            r_prev        <= n_prev;
            r_baseline    <= n_baseline;
            r_done        <= n_done;
        end
    end

    always_comb begin
        n_mode        = r_mode;
        n_tick        = r_tick;
        n_drive       = r_drive;
        n_full_seen   = r_full_seen;
        n_pulse_seen  = r_pulse_seen;
        n_full_phase  = r_full_phase;
        n_pulse_phase = r_pulse_phase;
        n_prev        = r_prev;
        n_baseline    = r_baseline;
        n_done        = r_done;
        s_valid       = 1'b0;
        s_runaway     = 1'b0;
        s_delta       = '0;
        s_mode_run    = r_mode;

        // Resolve the start mode on the first tick
        if (r_mode == MODE_START) begin
            n_drive = 1'b0;
            n_tick  = '0;
            if (s_on_ext >= s_per_ext) begin
                s_mode_run = MODE_FULL;
            end else if (i_on_ticks == TICK_WIDTH'(1)) begin
                s_mode_run = MODE_PULSE;
            end else begin
                s_mode_run = MODE_LOW;
            end
        end
        n_mode = s_mode_run;

        if (s_mode_run != MODE_DONE) begin
            case (s_mode_run)
                MODE_LOW: begin
                    if (n_tick == s_on_ext) begin
                        n_drive = 1'b1;
                        n_mode  = MODE_HIGH;
                    end
                end
                MODE_HIGH: begin
                    if (n_tick == s_per_ext) begin
                        n_tick  = '0;
                        n_drive = 1'b0;
                        if (!i_speed_switch_n) begin
                            n_mode = MODE_SPEED;
                        end else if (!i_stop_switch_n) begin
                            n_mode = MODE_STOP;
                        end else begin
                            n_mode = MODE_LOW;
                        end
                    end
                end
                MODE_SPEED: begin
                    s_valid = 1'b1;
                    // First sample only sets the baseline
                    if (r_baseline) begin
                        s_delta = DELTA_W'(signed'(s_enc_diff));
                    end
                    n_prev     = i_encoder_count;
                    n_baseline = 1'b1;
                    if (r_full_seen) begin
                        n_mode = MODE_FULL;
                    end else if (r_pulse_seen) begin
                        n_mode = MODE_PULSE;
                    end else begin
                        n_mode = MODE_LOW;
                    end
                end
                MODE_FULL: begin
                    n_full_seen = 1'b1;
                    n_drive     = 1'b0;
                    if (!i_stop_switch_n) begin
                        n_mode = MODE_STOP;
                    end
                    if (!i_speed_switch_n && r_full_phase == s_per_ext) begin
                        n_mode = MODE_SPEED;
                    end
                    n_full_phase = (s_full_inc > s_per_ext) ? '0 : s_full_inc;
                    n_tick       = '0;
                end
                MODE_PULSE: begin
                    n_pulse_seen  = 1'b1;
                    n_drive       = (r_pulse_phase != '0);
                    n_pulse_phase = s_pulse_wrap;
                    if (!i_stop_switch_n) begin
                        n_mode = MODE_STOP;
                    end
                    // Speed test uses the advanced phase
                    if (!i_speed_switch_n && s_pulse_wrap == s_per_ext) begin
                        n_mode = MODE_SPEED;
                    end
                    n_tick = '0;
                end
                MODE_ERROR: begin
                    n_drive = 1'b1;
                    n_mode  = MODE_STOP;
                end
                MODE_STOP: begin
                    n_drive = 1'b1;
                    n_done  = 1'b1;
                    n_mode  = MODE_DONE;
                end
                default: begin
                end
            endcase

            // Overrun check runs after every active tick, stop included
            n_tick = n_tick + CW'(1);
            if (n_tick == s_limit) begin
                n_mode    = MODE_ERROR;
                s_runaway = 1'b1;
            end
        end

        o_result.drive_off   = n_drive;
        o_result.speed_valid = s_valid;
        o_result.enc_delta   = s_delta;
        o_result.runaway     = s_runaway;
        o_result.halted      = n_done;
    end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Sends PWM tick requests to the motor mode controller over valid/ready.
// A software copy of the mode machine predicts each tick result, and every
// result field is checked against it. Period and on-time are retuned over
// APB between phases and read back. Sender and receiver idle at several
// rates. The run ends with a stop-switch halt that overruns on the stop tick.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pmmc_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int TICKS_PER_PHASE = 250;
    localparam int PHASE_COUNT     = 8;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    pmmc_in_if  tick_if ();
    pmmc_out_if result_if ();

    pwm_motor_mode_controller_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_if),
        .o_out   (result_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 i_clk = ~i_clk;

    // Predicted controller state and register copies
    logic [15:0] cfg_period  = 16'd10;
    logic [15:0] cfg_on      = 16'd5;
    t_mode       st_mode     = MODE_START;
    logic [16:0] st_ticks    = '0;
    logic        st_drive    = 1'b0;
    bit          full_seen   = 1'b0;
    bit          pulse_seen  = 1'b0;
    bit          st_halted   = 1'b0;
    logic [16:0] full_phase  = '0;
    logic [16:0] pulse_phase = '0;
    logic [31:0] base_count  = '0;
    bit          have_base   = 1'b0;

    t_result     awaited_results[$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    logic [31:0] enc_now        = '0;

    function automatic void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t mismatch on %s: expected %0h, got %0h", $time, what, want, got);
    endfunction

    // Run one tick through the mode machine and return its result.
    function automatic t_result advance_controller(bit stop_n, bit speed_n, logic [31:0] enc);
        t_result r;
        bit      stop_on;
        bit      speed_on;
        r        = '0;
        stop_on  = !stop_n;
        speed_on = !speed_n;
        if (st_mode == MODE_START) begin
            st_drive = 1'b0;
            st_ticks = '0;
            if (cfg_on >= cfg_period)
                st_mode = MODE_FULL;
            else if (cfg_on == 16'd1)
                st_mode = MODE_PULSE;
            else
                st_mode = MODE_LOW;
        end
        if (st_mode != MODE_DONE) begin
            case (st_mode)
                MODE_LOW: begin
                    if (st_ticks == {1'b0, cfg_on}) begin
                        st_drive = 1'b1;
                        st_mode  = MODE_HIGH;
                    end
                end
                MODE_HIGH: begin
                    if (st_ticks == {1'b0, cfg_period}) begin
                        st_ticks = '0;
                        st_drive = 1'b0;
                        if (speed_on)
                            st_mode = MODE_SPEED;
                        else if (stop_on)
                            st_mode = MODE_STOP;
                        else
                            st_mode = MODE_LOW;
                    end
                end
                MODE_SPEED: begin
                    r.speed_valid = 1'b1;
                    if (have_base)
                        r.enc_delta = enc - base_count;
                    base_count = enc;
                    have_base  = 1'b1;
                    if (full_seen)
                        st_mode = MODE_FULL;
                    else if (pulse_seen)
                        st_mode = MODE_PULSE;
                    else
                        st_mode = MODE_LOW;
                end
                MODE_FULL: begin
                    full_seen = 1'b1;
                    st_drive  = 1'b0;
                    if (stop_on)
                        st_mode = MODE_STOP;
                    if (speed_on && full_phase == {1'b0, cfg_period})
                        st_mode = MODE_SPEED;
                    full_phase = full_phase + 17'd1;
                    if (full_phase > {1'b0, cfg_period})
                        full_phase = '0;
                    st_ticks = '0;
                end
                MODE_PULSE: begin
                    pulse_seen  = 1'b1;
                    st_drive    = (pulse_phase != '0);
                    pulse_phase = pulse_phase + 17'd1;
                    if (pulse_phase > {1'b0, cfg_period})
                        pulse_phase = '0;
                    if (stop_on)
                        st_mode = MODE_STOP;
                    // speed test sees the phase after the increment
                    if (speed_on && pulse_phase == {1'b0, cfg_period})
                        st_mode = MODE_SPEED;
                    st_ticks = '0;
                end
                MODE_ERROR: begin
                    st_drive = 1'b1;
                    st_mode  = MODE_STOP;
                end
                default: begin
                    st_drive  = 1'b1;
                    st_halted = 1'b1;
                    st_mode   = MODE_DONE;
                end
            endcase
            // overrun check also runs on the stop tick
            st_ticks = st_ticks + 17'd1;
            if (st_ticks == 17'(cfg_period) + 17'd2) begin
                st_mode   = MODE_ERROR;
                r.runaway = 1'b1;
            end
        end
        r.drive_off = st_drive;
        r.halted    = st_halted;
        return r;
    endfunction

    // A tick here with the speed switch released consults the stop switch.
    function automatic bit at_period_end();
        return st_mode == MODE_HIGH && st_ticks == {1'b0, cfg_period};
    endfunction

    function automatic logic [31:0] next_count();
        case ($urandom_range(9))
            0: enc_now = $urandom();
            1: enc_now = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h8000_0000;
            2: enc_now = $urandom_range(1) ? 32'h0000_0000 : 32'h7FFF_FFFF;
            3: enc_now = enc_now - $urandom_range(40);
            default: enc_now = enc_now + $urandom_range(300);
        endcase
        return enc_now;
    endfunction

    task automatic send_tick(input bit stop_n, input bit speed_n, input logic [31:0] enc);
        while ($urandom_range(99) < send_idle_pct) begin
            tick_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        tick_if.valid          <= 1'b1;
        tick_if.stop_switch_n  <= stop_n;
        tick_if.speed_switch_n <= speed_n;
        tick_if.encoder_count  <= enc;
        @(posedge i_clk);
        while (!tick_if.ready)
            @(posedge i_clk);
        awaited_results.push_back(advance_controller(stop_n, speed_n, enc));
    endtask

    // Drop the request line and let every outstanding result drain.
    task automatic settle_results();
        tick_if.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_register(input logic reg_idx, input logic [15:0] value);
        logic [PADDR_W-1:0] reg_addr;
        reg_addr              = '0;
        reg_addr[REG_SEL_BIT] = reg_idx;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= reg_addr;
        pwdata  <= {16'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (reg_idx == REG_PERIOD)
            cfg_period = value;
        else
            cfg_on = value;
        @(posedge i_clk);
        psel   <= 1'b1;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (prdata !== {16'd0, value})
            flag_mismatch("register readback", {16'd0, value}, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Short period so the directed ticks cover several samples; low start.
    task automatic test_register_setup();
        program_register(REG_PERIOD, 16'd4);
        program_register(REG_ON, 16'd2);
    endtask

    // Samples land on ticks 5, 9, 13 and 17: first sample, wrap forward,
    // most negative and minus one deltas.
    task automatic test_directed_ticks();
        logic [31:0] probe_counts [24] = '{
            32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
            32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
            32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFE, 32'h1234_5678,
            32'h8000_0001, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
            32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h0000_0010, 32'hC000_0000,
            32'h0000_0000, 32'hFFFF_FFFF, 32'h0F0F_0F0F, 32'hF0F0_F0F0
        };
        bit stop_n;
        bit speed_n;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 24; i++) begin
            speed_n = (i >= 18);
            stop_n  = (speed_n && at_period_end()) ? 1'b1 : 1'(i % 2);
            send_tick(stop_n, speed_n, probe_counts[i]);
        end
        settle_results();
    endtask

    // Retune between phases with values the current tick count can still
    // reach, so the period keeps closing without an overrun.
    task automatic test_random_traffic();
        bit stop_n;
        bit speed_n;
        int lo_on;
        int lo_period;
        int new_on;
        int new_period;
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 74;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 74;
                end
                default: begin
                    send_idle_pct  = 17;
                    recv_stall_pct = 17;
                end
            endcase
            if (phase == 3) begin
                new_on     = 65534;
                new_period = 65535;
            end else begin
                lo_on = 2;
                if (st_mode == MODE_LOW && int'(st_ticks) > lo_on)
                    lo_on = int'(st_ticks);
                new_on    = lo_on + $urandom_range(6);
                lo_period = new_on + 1;
                if (st_mode == MODE_HIGH && int'(st_ticks) > lo_period)
                    lo_period = int'(st_ticks);
                new_period = lo_period + $urandom_range(8);
            end
            program_register(REG_PERIOD, new_period[15:0]);
            program_register(REG_ON, new_on[15:0]);
            for (int i = 0; i < TICKS_PER_PHASE; i++) begin
                speed_n = 1'($urandom_range(1));
                // hold the stop switch off where it would end the run
                stop_n  = (speed_n && at_period_end()) ? 1'b1 : 1'($urandom_range(1));
                send_tick(stop_n, speed_n, next_count());
            end
            settle_results();
        end
    endtask

    // Stop at a period end, then zero the period so the stop tick overruns.
    task automatic test_stop_and_halt();
        send_idle_pct  = 17;
        recv_stall_pct = 17;
        while (!at_period_end())
            send_tick(1'b1, 1'b1, next_count());
        send_tick(1'b0, 1'b1, next_count());
        settle_results();
        program_register(REG_PERIOD, 16'd0);
        for (int i = 0; i < 12; i++)
            send_tick(1'($urandom_range(1)), 1'($urandom_range(1)), next_count());
        settle_results();
        program_register(REG_ON, 16'd0);
        program_register(REG_ON, 16'hFFFF);
        program_register(REG_PERIOD, 16'hFFFF);
        for (int i = 0; i < 6; i++)
            send_tick(1'($urandom_range(1)), 1'($urandom_range(1)), next_count());
        settle_results();
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
            if (awaited_results.size() == 0) begin
                flag_mismatch("result with no request pending", '0, result_if.enc_delta);
            end else begin
                want = awaited_results.pop_front();
                if (result_if.drive_off !== want.drive_off)
                    flag_mismatch("drive_off", want.drive_off, result_if.drive_off);
                if (result_if.speed_valid !== want.speed_valid)
                    flag_mismatch("speed_valid", want.speed_valid, result_if.speed_valid);
                if (result_if.enc_delta !== want.enc_delta)
                    flag_mismatch("enc_delta", want.enc_delta, result_if.enc_delta);
                if (result_if.runaway !== want.runaway)
                    flag_mismatch("runaway", want.runaway, result_if.runaway);
                if (result_if.halted !== want.halted)
                    flag_mismatch("halted", want.halted, result_if.halted);
            end
        end
        result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n                <= 1'b0;
        psel                   <= 1'b0;
        penable                <= 1'b0;
        pwrite                 <= 1'b0;
        paddr                  <= '0;
        pwdata                 <= '0;
        tick_if.valid          <= 1'b0;
        tick_if.stop_switch_n  <= 1'b1;
        tick_if.speed_switch_n <= 1'b1;
        tick_if.encoder_count  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_register_setup();
        test_directed_ticks();
        test_random_traffic();
        test_stop_and_halt();
        mismatch_count += awaited_results.size();
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/pmmc_pkg.sv
rtl/pmmc_if.sv
rtl/pmmc_mode_fsm.sv
rtl/pwm_motor_mode_controller_unit.sv
dv/tb_top.sv
